[rtl/core/bdid_pkg.sv]
// ----------------------------------------------------------------------------
// bdid_pkg: shared types and constants of the beacon drone ID parser
// Record kinds, record and push structures, frame layout constants.
// ----------------------------------------------------------------------------
package bdid_pkg;

    // defaults for the top-level parameters
    localparam int MAX_ID_CHARS_DEF    = 20;
    localparam int MAX_FRAME_BYTES_DEF = 4096;

    localparam logic [23:0] VENDOR_OUI_RST = 24'h6a5c35;

    // frame layout
    localparam logic [7:0]  FC_BEACON     = 8'h80;
    localparam logic [7:0]  IE_VENDOR     = 8'hdd;
    localparam int          FIRST_ELEMENT = 36;
    localparam int          TLV_OFFSET    = 9;
    localparam logic [47:0] NAN_ADDR      = 48'h516f9a010000;

    // TLV types inside the drone element
    localparam logic [7:0] TLV_ID  = 8'd1;
    localparam logic [7:0] TLV_LOC = 8'd4;
    localparam logic [7:0] TLV_ALT = 8'd5;
    localparam logic [7:0] TLV_HGT = 8'd6;
    localparam logic [7:0] TLV_SPD = 8'd7;
    localparam logic [7:0] TLV_HDG = 8'd8;

    // record queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_ID   = 3'd0,
        KIND_LAT  = 3'd1,
        KIND_LON  = 3'd2,
        KIND_ALT  = 3'd3,
        KIND_HGT  = 3'd4,
        KIND_SPD  = 3'd5,
        KIND_HDG  = 3'd6,
        KIND_DONE = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  value;
        logic [4:0]   char_index;
        logic [47:0]  source_mac;
        logic         drone_found;
        logic         last;
    } t_record;

    // up to two records per byte; slot a always fills first
    typedef struct packed {
        logic    a_vld;
        logic    b_vld;
        t_record a;
        t_record b;
    } t_push;

endpackage

[rtl/core/bdid_parse.sv]
// ----------------------------------------------------------------------------
// bdid_parse: per-byte frame walker
// Tracks frame position, element chain and TLVs; pushes decoded records.
// ----------------------------------------------------------------------------
module bdid_parse
    import bdid_pkg::*;
#(
    parameter int MAX_ID_CHARS    = MAX_ID_CHARS_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic        i_mgmt,
    input  logic [23:0] i_oui,
    output t_push       o_push
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EXT_W = $clog2(MAX_FRAME_BYTES + 257);
    localparam logic [8:0] ID_LIM = 9'(MAX_ID_CHARS);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VAL
    } t_phase;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [EXT_W-1:0] r_nes,     n_nes;
    logic [EXT_W-1:0] r_limit,   n_limit;
    logic [EXT_W-1:0] r_nts,     n_nts;
    logic             r_rej,     n_rej;
    logic             r_nan_eq,  n_nan_eq;
    logic             r_matched, n_matched;
    logic             r_inside,  n_inside;
    logic [39:0]      r_hist,    n_hist;
    logic [4:0]       r_smask,   n_smask;
    logic [7:0]       r_type,    n_type;
    logic [7:0]       r_tlen,    n_tlen;
    logic [7:0]       r_k,       n_k;
    logic [31:0]      r_acc,     n_acc;
    logic [47:0]      r_mac,     n_mac;
    logic             r_id_stop, n_id_stop;
    t_phase           r_phase,   n_phase;

    logic             is_start;
    logic [EXT_W-1:0] p_ext;
    logic [EXT_W-1:0] elem_start;
    logic             data_vld;
    t_record          data_rec;
    t_record          done_rec;

    assign p_ext      = EXT_W'(r_pos);
    assign elem_start = p_ext - EXT_W'(4);

    always_comb begin
        n_pos     = r_pos;
        n_nes     = r_nes;
        n_limit   = r_limit;
        n_nts     = r_nts;
        n_rej     = r_rej;
        n_nan_eq  = r_nan_eq;
        n_matched = r_matched;
        n_inside  = r_inside;
        n_hist    = r_hist;
        n_smask   = r_smask;
        n_type    = r_type;
        n_tlen    = r_tlen;
        n_k       = r_k;
        n_acc     = r_acc;
        n_mac     = r_mac;
        n_id_stop = r_id_stop;
        n_phase   = r_phase;
        is_start  = 1'b0;
        data_vld  = 1'b0;
        data_rec  = '0;

        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);

            // header checks: beacon, management, not a NAN frame
            if (r_pos == '0 && (i_byte != FC_BEACON || !i_mgmt)) begin
                n_rej = 1'b1;
            end
            for (int j = 0; j < 6; j++) begin
                if (r_pos == POS_W'(4 + j) && i_byte != NAN_ADDR[8*(5-j) +: 8]) begin
                    n_nan_eq = 1'b0;
                end
                if (r_pos == POS_W'(10 + j)) begin
                    n_mac[8*(5-j) +: 8] = i_byte;
                end
            end
            if (r_pos == POS_W'(9) && n_nan_eq) begin
                n_rej = 1'b1;
            end

            if (!n_rej) begin
                if (!r_matched) begin
                    // element chain walk with a five byte look-back
                    is_start = (p_ext == r_nes);
                    n_hist   = {r_hist[31:0], i_byte};
                    n_smask  = {r_smask[3:0], is_start};
                    if (n_smask[1]) begin
                        n_nes = p_ext + EXT_W'(i_byte) + EXT_W'(1);
                    end
                    if (n_smask[4] && n_hist[39:32] == IE_VENDOR
                            && n_hist[23:0] == i_oui) begin
                        n_matched = 1'b1;
                        n_inside  = 1'b1;
                        n_limit   = elem_start + EXT_W'(n_hist[31:24]);
                        n_nts     = elem_start + EXT_W'(TLV_OFFSET);
                        n_phase   = PH_TYPE;
                    end
                end else if (r_inside) begin
                    case (r_phase)
                        PH_TYPE: begin
                            if (p_ext == r_nts) begin
                                if (p_ext < r_limit) begin
                                    n_type  = i_byte;
                                    n_phase = PH_LEN;
                                end else begin
                                    n_inside = 1'b0;
                                end
                            end
                        end
                        PH_LEN: begin
                            n_tlen    = i_byte;
                            n_nts     = p_ext + EXT_W'(i_byte) + EXT_W'(1);
                            n_phase   = (i_byte != 8'd0) ? PH_VAL : PH_TYPE;
                            n_id_stop = 1'b0;
                            n_acc     = '0;
                            n_k       = '0;
                        end
                        PH_VAL: begin
                            n_acc = {r_acc[23:0], i_byte};
                            n_k   = r_k + 8'd1;
                            case (r_type)
                                TLV_ID: begin
                                    if (i_byte == 8'd0) begin
                                        n_id_stop = 1'b1;
                                    end
                                    if (!n_id_stop && 9'(r_k) < ID_LIM) begin
                                        data_vld            = 1'b1;
                                        data_rec.kind       = KIND_ID;
                                        data_rec.value      = 32'(i_byte);
                                        data_rec.char_index = r_k[4:0];
                                    end
                                end
                                TLV_LOC: begin
                                    if (r_k == 8'd3) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_LAT;
                                        data_rec.value = n_acc;
                                    end
                                    if (r_k == 8'd7) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_LON;
                                        data_rec.value = n_acc;
                                    end
                                end
                                TLV_ALT: begin
                                    if (r_k == 8'd1) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_ALT;
                                        data_rec.value = {{16{n_acc[15]}}, n_acc[15:0]};
                                    end
                                end
                                TLV_HGT: begin
                                    if (r_k == 8'd1) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_HGT;
                                        data_rec.value = {{16{n_acc[15]}}, n_acc[15:0]};
                                    end
                                end
                                TLV_SPD: begin
                                    if (r_k == 8'd0) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_SPD;
                                        data_rec.value = 32'(i_byte);
                                    end
                                end
                                TLV_HDG: begin
                                    if (r_k == 8'd1) begin
                                        data_vld       = 1'b1;
                                        data_rec.kind  = KIND_HDG;
                                        data_rec.value = {16'd0, n_acc[15:0]};
                                    end
                                end
                                default: begin
                                end
                            endcase
                            if (9'(r_k) + 9'd1 >= 9'(r_tlen)) begin
                                n_phase = PH_TYPE;
                            end
                        end
                        default: begin
                            n_phase = PH_TYPE;
                        end
                    endcase
                end
            end
        end

        done_rec             = '0;
        done_rec.kind        = KIND_DONE;
        done_rec.source_mac  = n_mac;
        done_rec.drone_found = n_matched && !n_rej;
        done_rec.last        = 1'b1;

        // end of frame: back to the idle frame state
        if (i_last) begin
            n_pos     = '0;
            n_nes     = EXT_W'(FIRST_ELEMENT);
            n_limit   = '0;
            n_nts     = '0;
            n_rej     = 1'b0;
            n_nan_eq  = 1'b1;
            n_matched = 1'b0;
            n_inside  = 1'b0;
            n_hist    = '0;
            n_smask   = '0;
            n_type    = '0;
            n_tlen    = '0;
            n_k       = '0;
            n_acc     = '0;
            n_mac     = '0;
            n_id_stop = 1'b0;
            n_phase   = PH_TYPE;
        end
    end

    always_comb begin
        o_push = '0;
        if (i_adv) begin
            if (data_vld) begin
                o_push.a_vld = 1'b1;
                o_push.a     = data_rec;
                o_push.b_vld = i_last;
                o_push.b     = done_rec;
            end else begin
                o_push.a_vld = i_last;
                o_push.a     = done_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_nes     <= EXT_W'(FIRST_ELEMENT);
            r_limit   <= '0;
            r_nts     <= '0;
            r_rej     <= 1'b0;
            r_nan_eq  <= 1'b1;
            r_matched <= 1'b0;
            r_inside  <= 1'b0;
            r_hist    <= '0;
            r_smask   <= '0;
            r_type    <= '0;
            r_tlen    <= '0;
            r_k       <= '0;
            r_acc     <= '0;
            r_mac     <= '0;
            r_id_stop <= 1'b0;
            r_phase   <= PH_TYPE;
        end else if (i_adv) begin
            r_pos     <= n_pos;
            r_nes     <= n_nes;
            r_limit   <= n_limit;
            r_nts     <= n_nts;
            r_rej     <= n_rej;
            r_nan_eq  <= n_nan_eq;
            r_matched <= n_matched;
            r_inside  <= n_inside;
            r_hist    <= n_hist;
            r_smask   <= n_smask;
            r_type    <= n_type;
            r_tlen    <= n_tlen;
            r_k       <= n_k;
            r_acc     <= n_acc;
            r_mac     <= n_mac;
            r_id_stop <= n_id_stop;
            r_phase   <= n_phase;
        end
    end

    // frame done always closes the pair of records pushed in one cycle
    a_done_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.b_vld |-> (o_push.a_vld && o_push.b.kind == KIND_DONE))
        else $error("second record of a byte is not frame done");

    // TLV walk only runs inside a matched element
    a_inside_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> r_matched)
        else $error("TLV walk active without a matched element");

endmodule

[rtl/core/bdid_rec_fifo.sv]
// ----------------------------------------------------------------------------
// bdid_rec_fifo: small record queue
// Takes up to two records a cycle, hands out one per output transfer.
// ----------------------------------------------------------------------------
module bdid_rec_fifo
    import bdid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_stall,
    output logic    o_vld,
    output t_record o_rec,
    output logic    o_room2
);

    t_record              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;

    logic                 pop;
    logic [OUT_CNT_W-1:0] push_n;
    logic [OUT_PTR_W-1:0] wr_ptr_1;

    assign o_vld    = (r_count != '0);
    assign o_rec    = r_mem[r_rd_ptr];
    assign o_room2  = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign pop      = o_vld && !i_stall;
    assign push_n   = OUT_CNT_W'(i_push.a_vld) + OUT_CNT_W'(i_push.b_vld);
    assign wr_ptr_1 = r_wr_ptr + OUT_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.a_vld) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_vld) begin
            r_mem[wr_ptr_1] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + push_n - OUT_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_count) + 4'(push_n)) <= 4'(OUT_DEPTH))
        else $error("record queue overflow");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.b_vld |-> i_push.a_vld)
        else $error("second slot pushed without the first");

endmodule

[rtl/core/beacon_drone_id_parser_top.sv]
// ----------------------------------------------------------------------------
// beacon_drone_id_parser_top: beacon drone ID element parser
// Byte-stream parser for drone ID vendor elements in received beacons.
// ----------------------------------------------------------------------------
// The block takes a received management frame one byte per transfer, from
// the first frame control byte on, and emits one record per decoded drone
// field (ID characters, latitude, longitude, altitude, height, speed,
// heading) as soon as the field's last byte has arrived, followed on the
// final byte of each frame by a frame done record with the transmitter
// address and a found flag. Only beacons that are not NAN frames are parsed,
// and only the first vendor element whose OUI equals the configured value.
// Throughput is one frame byte per clock while the record queue has room
// for two records. A byte goes from the input register through one pass
// of parse logic into a four-entry record queue that registers its records.
// A byte can yield two records (a field and frame done), and the input is
// stalled only while fewer than two queue entries are free, so a steady
// stall on the output side is what holds the input back.
// The OUI register may be written only while no frame bytes are in flight.
// ----------------------------------------------------------------------------
module beacon_drone_id_parser_top
    import bdid_pkg::*;
#(
    parameter int MAX_ID_CHARS    = MAX_ID_CHARS_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration: vendor OUI, first byte in bits 23..16
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,

    // frame byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_frame_byte,
    input  logic               i_frame_last,
    input  logic               i_frame_is_mgmt,

    // record output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_record_kind,
    output logic signed [31:0] o_record_value,
    output logic [4:0]         o_char_index,
    output logic [47:0]        o_source_mac,
    output logic               o_drone_found,
    output logic               o_record_last
);

    logic [23:0] r_oui;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_in_mgmt;

    logic        adv;
    logic        in_xfer;
    logic        room2;
    t_push       push;
    t_record     out_rec;

    // the held byte moves on when the queue can take two records
    assign adv        = r_in_vld && room2;
    assign o_in_stall = r_in_vld && !room2;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oui <= VENDOR_OUI_RST;
        end else if (i_cfg_we) begin
            r_oui <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_frame_last;
            r_in_mgmt <= i_frame_is_mgmt;
        end
    end

    bdid_parse #(
        .MAX_ID_CHARS    (MAX_ID_CHARS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_mgmt  (r_in_mgmt),
        .i_oui   (r_oui),
        .o_push  (push)
    );

    bdid_rec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_out_stall),
        .o_vld   (o_out_valid),
        .o_rec   (out_rec),
        .o_room2 (room2)
    );

    assign o_record_kind  = out_rec.kind;
    assign o_record_value = out_rec.value;
    assign o_char_index   = out_rec.char_index;
    assign o_source_mac   = out_rec.source_mac;
    assign o_drone_found  = out_rec.drone_found;
    assign o_record_last  = out_rec.last;

    // a stall is only raised while a byte is held in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld)
        else $error("input stalled with the input register empty");

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_record_last == (o_record_kind == KIND_DONE)))
        else $error("record_last does not match a frame done record");

    a_index_only_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_kind != KIND_ID) |-> (o_char_index == 5'd0))
        else $error("char index set on a non-ID record");

endmodule

[verif/bdid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdid_checker: record checker for the beacon drone ID parser
// Watches the byte and record channels, decodes every accepted frame byte
// into the records it should cause and compares each record on arrival.
// ----------------------------------------------------------------------------
module bdid_checker
    import bdid_pkg::*;
#(
    parameter int MAX_ID_CHARS    = MAX_ID_CHARS_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_frame_byte,
    input  logic               i_frame_last,
    input  logic               i_frame_is_mgmt,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_record_kind,
    input  logic signed [31:0] i_record_value,
    input  logic [4:0]         i_char_index,
    input  logic [47:0]        i_source_mac,
    input  logic               i_drone_found,
    input  logic               i_record_last,

    output int                 o_fail_count,
    output int                 o_pending
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VALUE
    } t_tlv_phase;

    t_record     expected_records[$];

    logic [23:0] oui;
    int unsigned byte_pos;
    int unsigned elem_next;
    logic [7:0]  elem_len;
    logic        rejected;
    logic        matched;
    logic        in_elem;
    logic        nan_same;
    logic [47:0] mac;
    logic [39:0] hist;
    logic [4:0]  start_mask;
    int unsigned tlv_limit;
    int unsigned tlv_next;
    int unsigned tlv_base;
    t_tlv_phase  tlv_phase;
    logic [7:0]  tlv_kind;
    logic [7:0]  tlv_len;
    logic [31:0] acc;
    logic        id_stop;
    t_record     want;

    task automatic clear_frame();
        byte_pos   = 0;
        elem_next  = FIRST_ELEMENT;
        elem_len   = '0;
        rejected   = 1'b0;
        matched    = 1'b0;
        in_elem    = 1'b0;
        nan_same   = 1'b1;
        mac        = '0;
        hist       = '0;
        start_mask = '0;
        tlv_limit  = 0;
        tlv_next   = 0;
        tlv_base   = 0;
        tlv_phase  = PH_TYPE;
        tlv_kind   = '0;
        tlv_len    = '0;
        acc        = '0;
        id_stop    = 1'b0;
    endtask

    task automatic push_field(t_kind kind, logic [31:0] value, logic [4:0] idx);
        t_record r;
        r = '0;
        r.kind       = kind;
        r.value      = value;
        r.char_index = idx;
        expected_records.push_back(r);
    endtask

    // one byte inside the drone element: TLV type, length, then value bytes
    task automatic decode_tlv_byte(int unsigned p, logic [7:0] b);
        int unsigned k;
        if (tlv_phase == PH_TYPE) begin
            if (p != tlv_next)
                return;
            if (p < tlv_limit) begin
                tlv_kind  = b;
                tlv_base  = p;
                tlv_phase = PH_LEN;
            end else begin
                in_elem = 1'b0;
            end
            return;
        end
        if (tlv_phase == PH_LEN) begin
            tlv_len   = b;
            tlv_next  = p + 1 + b;
            tlv_phase = (b != 0) ? PH_VALUE : PH_TYPE;
            id_stop   = 1'b0;
            acc       = '0;
            return;
        end
        k   = p - tlv_base - 2;
        acc = {acc[23:0], b};
        case (tlv_kind)
            TLV_ID: begin
                if (b == 8'd0)
                    id_stop = 1'b1;
                if (!id_stop && k < MAX_ID_CHARS)
                    push_field(KIND_ID, {24'd0, b}, k[4:0]);
            end
            TLV_LOC: begin
                if (k == 3)
                    push_field(KIND_LAT, acc, 5'd0);
                if (k == 7)
                    push_field(KIND_LON, acc, 5'd0);
            end
            TLV_ALT: if (k == 1) push_field(KIND_ALT, {{16{acc[15]}}, acc[15:0]}, 5'd0);
            TLV_HGT: if (k == 1) push_field(KIND_HGT, {{16{acc[15]}}, acc[15:0]}, 5'd0);
            TLV_SPD: if (k == 0) push_field(KIND_SPD, {24'd0, b}, 5'd0);
            TLV_HDG: if (k == 1) push_field(KIND_HDG, {16'd0, acc[15:0]}, 5'd0);
            default: ;
        endcase
        if (k + 1 >= tlv_len)
            tlv_phase = PH_TYPE;
    endtask

    task automatic decode_frame_byte(logic [7:0] b, logic last, logic mgmt);
        int unsigned p;
        int unsigned e;
        t_record     done;
        p = byte_pos;
        if (p < MAX_FRAME_BYTES) begin
            byte_pos = p + 1;
            if (p == 0 && (b != FC_BEACON || !mgmt))
                rejected = 1'b1;
            if (p >= 4 && p <= 9) begin
                if (b != NAN_ADDR[8*(9-p) +: 8])
                    nan_same = 1'b0;
                if (p == 9 && nan_same)
                    rejected = 1'b1;
            end
            if (p >= 10 && p <= 15)
                mac = mac | (48'(b) << (8 * (15 - p)));
            if (!rejected) begin
                // element walk runs until the first matching vendor element
                if (!matched) begin
                    hist       = {hist[31:0], b};
                    start_mask = {start_mask[3:0], p == elem_next};
                    if (start_mask[1])
                        elem_next = p + 1 + b;
                    if (start_mask[4] && hist[39:32] == IE_VENDOR && hist[23:0] == oui) begin
                        e         = p - 4;
                        matched   = 1'b1;
                        in_elem   = 1'b1;
                        elem_len  = hist[31:24];
                        tlv_limit = e + elem_len;
                        tlv_next  = e + TLV_OFFSET;
                        tlv_phase = PH_TYPE;
                    end
                end
                if (in_elem)
                    decode_tlv_byte(p, b);
            end
        end
        if (last) begin
            done             = '0;
            done.kind        = KIND_DONE;
            done.source_mac  = mac;
            done.drone_found = matched && !rejected;
            done.last        = 1'b1;
            expected_records.push_back(done);
            clear_frame();
        end
    endtask

    task automatic compare_field(string name, logic [47:0] exp_val, logic [47:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;
    initial o_pending    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            oui = VENDOR_OUI_RST;
            clear_frame();
            expected_records.delete();
        end else begin
            if (i_cfg_we)
                oui = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                decode_frame_byte(i_frame_byte, i_frame_last, i_frame_is_mgmt);
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record: kind %0d value %0h", i_record_kind,
                           i_record_value);
                    o_fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    compare_field("record_kind", 48'(want.kind), 48'(i_record_kind));
                    compare_field("record_value", 48'(want.value),
                                  {16'd0, i_record_value});
                    compare_field("char_index", 48'(want.char_index), 48'(i_char_index));
                    compare_field("source_mac", want.source_mac, i_source_mac);
                    compare_field("drone_found", 48'(want.drone_found),
                                  48'(i_drone_found));
                    compare_field("record_last", 48'(want.last), 48'(i_record_last));
                end
            end
        end
        o_pending = expected_records.size();
    end

endmodule

[verif/tb_beacon_drone_id_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beacon_drone_id_parser_top: testbench of the beacon drone ID parser
// Feeds whole frames byte by byte, directed ones first and then random
// beacons around a drone element, under random gaps and output stalls.
// Records are checked by bdid_checker; this module makes the stimulus,
// writes the OUI register between phases and gives the verdict.
// ----------------------------------------------------------------------------
module tb_beacon_drone_id_parser_top
    import bdid_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int DRAIN_WAIT  = 20;      // settle time after the last record

    // drone element length byte choices
    localparam int LEN_EXACT  = 0;        // covers every TLV that was built
    localparam int LEN_RANDOM = 1;        // may cut the TLV walk or run long
    localparam int LEN_SHORT  = 2;        // too short to hold any TLV

    // address 1 choices in the header
    localparam int NAN_NONE  = 0;
    localparam int NAN_EXACT = 1;
    localparam int NAN_NEAR  = 2;         // one bit away from the NAN address

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [23:0]        i_cfg_wdata     = '0;
    logic               i_in_valid      = 1'b0;
    logic [7:0]         i_frame_byte    = '0;
    logic               i_frame_last    = 1'b0;
    logic               i_frame_is_mgmt = 1'b0;
    logic               i_out_stall     = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_record_kind;
    logic signed [31:0] o_record_value;
    logic [4:0]         o_char_index;
    logic [47:0]        o_source_mac;
    logic               o_drone_found;
    logic               o_record_last;

    int                 fail_count;
    int                 pending;
    int unsigned        cycle_count = 0;

    // frame under construction and the TLVs of the next drone element
    logic [7:0]         frame_buf[$];
    logic [7:0]         tlv_buf[$];
    logic               frame_mgmt;
    logic [23:0]        cur_oui;
    logic [23:0]        oui_plan[4];

    bit                 hold_req  = 1'b0;
    int                 calm_left = 0;

    always #5 i_clk = ~i_clk;

    beacon_drone_id_parser_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frame_byte    (i_frame_byte),
        .i_frame_last    (i_frame_last),
        .i_frame_is_mgmt (i_frame_is_mgmt),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_record_kind   (o_record_kind),
        .o_record_value  (o_record_value),
        .o_char_index    (o_char_index),
        .o_source_mac    (o_source_mac),
        .o_drone_found   (o_drone_found),
        .o_record_last   (o_record_last)
    );

    bdid_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_frame_byte    (i_frame_byte),
        .i_frame_last    (i_frame_last),
        .i_frame_is_mgmt (i_frame_is_mgmt),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_record_kind   (o_record_kind),
        .i_record_value  (o_record_value),
        .i_char_index    (o_char_index),
        .i_source_mac    (o_source_mac),
        .i_drone_found   (o_drone_found),
        .i_record_last   (o_record_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Watchdog: a hung handshake or a lost record ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_beacon_drone_id_parser_top failed");
            $finish;
        end
    end

    // Idle length for either side. Mostly none or short, now and then long,
    // and every so often a calm stretch where neither side idles at all.
    function automatic int pick_idle();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm_left = $urandom_range(50, 200);
            return 0;
        end
        if (r < 550)
            return 0;
        if (r < 900)
            return $urandom_range(1, 3);
        if (r < 985)
            return $urandom_range(4, 12);
        return $urandom_range(16, 40);
    endfunction

    // Receiver: random stall runs, plus one long hold-off on request so the
    // record queue fills and the block has to stall its input. Each loop
    // pass puts at most one assignment on the stall in a given step.
    initial begin : receiver
        int stall_len;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge i_clk);
            end else begin
                stall_len = pick_idle();
                if (stall_len > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (stall_len) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // One byte transfer. Called at a rising edge; the stall is sampled at
    // the falling edge, where it already holds its value for the next rise.
    task automatic send_byte(logic [7:0] b, logic last, logic mgmt);
        int gap;
        bit taken;
        gap = pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_frame_byte    <= b;
        i_frame_last    <= last;
        i_frame_is_mgmt <= mgmt;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Only byte 0 carries the management flag; elsewhere it is noise.
    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1,
                      (i == 0) ? frame_mgmt : 1'($urandom));
    endtask

    // Frame control, duration, address 1 (NAN check), address 2 (the
    // transmitter), address 3, sequence, timestamp, interval, capability:
    // 36 bytes before the first element.
    task automatic add_header(logic [7:0] fc, int nan_mode);
        int flip;
        flip = $urandom_range(0, 5);
        frame_buf.push_back(fc);
        repeat (3) frame_buf.push_back(8'($urandom));
        for (int i = 0; i < 6; i++) begin
            if (nan_mode == NAN_NONE)
                frame_buf.push_back(8'($urandom));
            else
                frame_buf.push_back(NAN_ADDR[8*(5-i) +: 8] ^
                    ((nan_mode == NAN_NEAR && i == flip) ?
                     8'(1 << $urandom_range(0, 7)) : 8'h00));
        end
        repeat (26) frame_buf.push_back(8'($urandom));
    endtask

    task automatic add_element(logic [7:0] kind, int len);
        frame_buf.push_back(kind);
        frame_buf.push_back(len[7:0]);
        repeat (len) frame_buf.push_back(8'($urandom));
    endtask

    // Value goes out big-endian; bytes beyond the low eight are random.
    task automatic add_tlv(logic [7:0] kind, int len, logic [63:0] val);
        tlv_buf.push_back(kind);
        tlv_buf.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            tlv_buf.push_back((len - 1 - i < 8) ? val[8*(len-1-i) +: 8] : 8'($urandom));
    endtask

    // nul_at < 0 gives an identifier without a terminating NUL
    task automatic add_id_tlv(int len, int nul_at);
        tlv_buf.push_back(TLV_ID);
        tlv_buf.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            tlv_buf.push_back((i == nul_at) ? 8'h00 : 8'($urandom_range(1, 255)));
    endtask

    // Vendor element: type, length, OUI, four spare bytes, then the TLVs,
    // which start at element byte 9.
    task automatic add_drone_element(logic [23:0] oui, int len_mode);
        int body;
        case (len_mode)
            LEN_EXACT:  body = tlv_buf.size() + 7;
            LEN_RANDOM: body = $urandom_range(0, 255);
            default:    body = $urandom_range(0, 8);
        endcase
        if (body > 255)
            body = 255;
        frame_buf.push_back(IE_VENDOR);
        frame_buf.push_back(body[7:0]);
        frame_buf.push_back(oui[23:16]);
        frame_buf.push_back(oui[15:8]);
        frame_buf.push_back(oui[7:0]);
        repeat (4) frame_buf.push_back(8'($urandom));
        foreach (tlv_buf[i])
            frame_buf.push_back(tlv_buf[i]);
        tlv_buf.delete();
    endtask

    // mostly the natural size of the field, sometimes an odd one
    function automatic int tlv_size(int natural);
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : natural;
    endfunction

    task automatic gen_tlvs();
        int count;
        count = $urandom_range(0, 6);
        repeat (count) begin
            if (tlv_buf.size() > 200)
                break;
            case ($urandom_range(0, 7))
                0: add_id_tlv($urandom_range(0, 24),
                              ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 24)) : -1);
                1: add_tlv(TLV_LOC, tlv_size(8), {$urandom, $urandom});
                2: add_tlv(TLV_ALT, tlv_size(2), {$urandom, $urandom});
                3: add_tlv(TLV_HGT, tlv_size(2), {$urandom, $urandom});
                4: add_tlv(TLV_SPD, tlv_size(1), {$urandom, $urandom});
                5: add_tlv(TLV_HDG, tlv_size(2), {$urandom, $urandom});
                6: add_tlv(8'($urandom), $urandom_range(0, 10), {$urandom, $urandom});
                default: add_tlv(8'($urandom_range(0, 9)), 0, 64'd0);
            endcase
        end
    endtask

    // Mostly well-formed beacons with random content around a drone
    // element; the rest is noise, rejected frames and cut-off frames.
    task automatic build_random_frame();
        int  r;
        int  cut;
        logic [23:0] oui;
        frame_buf.delete();
        frame_mgmt = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            frame_mgmt = 1'($urandom);
            frame_buf.push_back(($urandom_range(0, 1) == 0) ? FC_BEACON : 8'($urandom));
            repeat ($urandom_range(0, 59)) frame_buf.push_back(8'($urandom));
            return;
        end
        if (r >= 25 && r < 30)
            frame_mgmt = 1'b0;
        add_header((r < 15) ? 8'($urandom) : FC_BEACON,
                   (r < 20) ? NAN_EXACT : ((r < 25) ? NAN_NEAR : NAN_NONE));
        repeat ($urandom_range(0, 2)) add_element(8'($urandom), $urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0) begin
            oui = cur_oui;
            if ($urandom_range(0, 7) == 0)
                oui = oui ^ 24'(1 << $urandom_range(0, 23));
            gen_tlvs();
            case ($urandom_range(0, 9))
                0, 1:    add_drone_element(oui, LEN_RANDOM);
                2:       add_drone_element(oui, LEN_SHORT);
                default: add_drone_element(oui, LEN_EXACT);
            endcase
        end
        // a later matching element must be ignored
        if ($urandom_range(0, 3) == 0) begin
            gen_tlvs();
            add_drone_element(cur_oui, LEN_EXACT);
        end
        repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut)
                frame_buf.pop_back();
        end
    endtask

    task automatic run_random(int byte_goal);
        int sent;
        sent = 0;
        while (sent < byte_goal) begin
            build_random_frame();
            sent += frame_buf.size();
            send_frame();
        end
    endtask

    // Drop valid and wait until every expected record is out, then let the
    // pipeline settle; leaves us at a rising edge.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_oui(logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cur_oui = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_oui = VENDOR_OUI_RST;

        // -- directed part, OUI still at its reset value --

        // one-byte frame: no MAC bytes ever arrive
        frame_buf = '{FC_BEACON};
        frame_mgmt = 1'b1;
        send_frame();

        // two-byte frame, wrong frame control at both extremes
        frame_buf = '{8'h00, 8'hff};
        send_frame();

        // full drone beacon, but not flagged as management
        frame_buf.delete();
        frame_mgmt = 1'b0;
        add_header(FC_BEACON, NAN_NONE);
        add_tlv(TLV_SPD, 1, 64'h12);
        add_drone_element(cur_oui, LEN_EXACT);
        send_frame();

        // drone beacon sent to the NAN address
        frame_buf.delete();
        frame_mgmt = 1'b1;
        add_header(FC_BEACON, NAN_EXACT);
        add_tlv(TLV_SPD, 1, 64'h34);
        add_drone_element(cur_oui, LEN_EXACT);
        send_frame();

        // every TLV type with extreme values, an overlong identifier,
        // an identifier stopped by NUL, repeats, unknown and empty TLVs,
        // a short foreign vendor element ahead and a second match behind
        frame_buf.delete();
        add_header(FC_BEACON, NAN_NEAR);
        add_element(8'h00, 0);
        add_element(IE_VENDOR, 2);
        add_id_tlv(22, -1);
        add_tlv(TLV_LOC, 8, 64'h80000000_7fffffff);
        add_tlv(TLV_ALT, 2, 64'h8000);
        add_tlv(TLV_HGT, 2, 64'h7fff);
        add_tlv(TLV_SPD, 1, 64'hff);
        add_tlv(TLV_HDG, 2, 64'hffff);
        add_tlv(TLV_SPD, 1, 64'h00);
        add_id_tlv(6, 3);
        add_tlv(8'h2a, 3, 64'h0);
        add_tlv(TLV_LOC, 0, 64'h0);
        add_tlv(TLV_LOC, 8, 64'h7fffffff_80000000);
        add_tlv(TLV_ALT, 2, 64'h7fff);
        add_tlv(TLV_HGT, 2, 64'h8000);
        add_tlv(TLV_HDG, 2, 64'h0000);
        add_drone_element(cur_oui, LEN_EXACT);
        add_tlv(TLV_SPD, 1, 64'h55);
        add_drone_element(cur_oui, LEN_EXACT);
        send_frame();

        // -- random part, with the long receiver hold-off early on --
        hold_req = 1'b1;
        run_random(80);

        // OUI settings: both extremes, a random one, and back to reset
        oui_plan[0] = 24'h000000;
        oui_plan[1] = 24'hffffff;
        oui_plan[2] = 24'($urandom);
        oui_plan[3] = VENDOR_OUI_RST;
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_oui(oui_plan[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            run_random(50);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_beacon_drone_id_parser_top passed");
        else
            $display("tb_beacon_drone_id_parser_top failed");
        $finish;
    end

endmodule
